// ===== hdl/msta_pkg.sv =====
// Shared constants, codes and types of the timestamp aligner.
`timescale 1ns / 1ps
`default_nettype none

package msta_pkg;

  // Default sizing of the slot store.
  localparam int MAX_CHANNELS_DEF = 8;
  localparam int HANDLE_BITS_DEF  = 8;

  // Channel limit that the channel field and the result count allow.
  localparam int HW_CHAN_LIMIT = 8;

  // Field widths of the input and result beats.
  localparam int CHAN_W   = 3;
  localparam int TIME_W   = 64;
  localparam int HANDLE_W = 8;
  localparam int KIND_W   = 3;

  // Configuration register file.
  localparam int                CFG_W     = 4;
  localparam logic [CFG_W-1:0]  CFG_RESET = 4'd8;
  localparam int                APB_AW    = 3;
  localparam int                APB_DW    = 32;

  // Register indexes, taken from the word address bit of paddr.
  typedef enum logic [0:0] {
    REG_CHANNELS_IN_USE = 1'b0
  } reg_idx_e;

  // Result kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_RELEASED  = 3'd0,
    KIND_DELIVERED = 3'd1,
    KIND_SKIPPED   = 3'd2,
    KIND_BUSY      = 3'd3,
    KIND_BADCHAN   = 3'd4
  } kind_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_EMIT_RD,
    ST_EMIT_WAIT
  } state_e;

endpackage

`default_nettype wire

// ===== hdl/msta_if.sv =====
// Valid/ready stream interfaces for frame beats and result beats.
`timescale 1ns / 1ps
`default_nettype none

interface msta_in_if import msta_pkg::*;;
  logic                valid;
  logic                ready;
  logic [CHAN_W-1:0]   channel;
  logic [TIME_W-1:0]   frame_time;
  logic [HANDLE_W-1:0] buffer_handle;
  logic                consumer_waiting;

  modport source (output valid, channel, frame_time, buffer_handle, consumer_waiting,
                  input ready);
  modport sink   (input valid, channel, frame_time, buffer_handle, consumer_waiting,
                  output ready);
endinterface

interface msta_out_if import msta_pkg::*;;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [CHAN_W-1:0]   out_channel;
  logic [HANDLE_W-1:0] out_handle;
  logic [TIME_W-1:0]   out_time;
  logic                last;

  modport source (output valid, kind, out_channel, out_handle, out_time, last,
                  input ready);
  modport sink   (input valid, kind, out_channel, out_handle, out_time, last,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/multi_stream_timestamp_aligner.sv =====
// Top level of the multi-stream timestamp aligner.
//
// Frames arrive on in_i, one per beat: channel, timestamp, buffer handle and
// the consumer-waiting flag. Results leave on out_o, one per beat, with last
// set on the final result that a frame causes. The APB port holds the
// channels_in_use register at byte address 0; pready is always high.
// A frame for an inactive channel or an occupied slot gives one result in the
// cycle after it is taken. A frame that leaves the set incomplete is stored
// and gives no result. A frame that completes the set starts a scan of the
// slot memory for the largest timestamp, one active slot after the other,
// then an emit pass that reads each slot that gives a result and steps over
// each kept slot below the last released one; in_i is not ready again until
// the emit pass ends. Both passes go through the single read port of the
// slot memory.
// The output register takes a result while the previous one drains, so a
// stalled receiver simply holds the sequencer in the emit pass, and in_i is
// not ready until the pass ends. Reset clears all slot flags and sets
// channels_in_use to 8; slot contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module multi_stream_timestamp_aligner import msta_pkg::*; #(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int HANDLE_BITS  = HANDLE_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  msta_in_if.sink                in_i,
  msta_out_if.source             out_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  // Slot count, handle bits kept and memory geometry.
  localparam int NSLOT = (MAX_CHANNELS < HW_CHAN_LIMIT) ? MAX_CHANNELS : HW_CHAN_LIMIT;
  localparam int KB    = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
  localparam int AW    = (NSLOT > 1) ? $clog2(NSLOT) : 1;
  localparam int MW    = TIME_W + KB;
  localparam logic [CFG_W-1:0] CAP = CFG_W'(NSLOT);

  // Configuration register.
  logic [CFG_W-1:0] cfg_q;
  logic             cfg_we;
  reg_idx_e         reg_idx;

  assign reg_idx = reg_idx_e'(paddr[2]);
  assign cfg_we  = psel && penable && pwrite && (reg_idx == REG_CHANNELS_IN_USE);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we) begin
      cfg_q <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_CHANNELS_IN_USE) begin
      prdata = APB_DW'(cfg_q);
    end
  end

  // Active channel count with the out-of-range codes clamped.
  logic [CFG_W-1:0] n_act;
  logic [AW-1:0]    last_idx;
  logic [NSLOT-1:0] act_mask;

  always_comb begin
    if (cfg_q == '0) begin
      n_act = CFG_W'(1);
    end else if (cfg_q > CAP) begin
      n_act = CAP;
    end else begin
      n_act = cfg_q;
    end
    last_idx = AW'(n_act - CFG_W'(1));
    for (int j = 0; j < NSLOT; j++) begin
      act_mask[j] = (CFG_W'(j) < n_act);
    end
  end

  // Sequencer and working registers.
  state_e           state_q, state_d;
  logic [AW-1:0]    idx_q, idx_d;
  logic             wait_q, wait_d;
  logic [NSLOT-1:0] full_q;
  logic [NSLOT-1:0] mask_q;
  logic [TIME_W-1:0] max_q;
  logic             scan_v_q;
  logic [AW-1:0]    ridx_q;

  // Slot memory: timestamp above the kept handle bits.
  logic [MW-1:0]    mem [NSLOT];
  logic [MW-1:0]    rdata_q;
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr;
  logic [MW-1:0]    mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[idx_q];
    end
  end

  logic [TIME_W-1:0] rd_time;
  logic [KB-1:0]     rd_handle;
  assign rd_time   = rdata_q[KB +: TIME_W];
  assign rd_handle = rdata_q[KB-1:0];

  // Input decode.
  logic              in_fire;
  logic              out_free;
  logic [AW-1:0]     ch_idx;
  logic              ch_bad;
  logic              ch_busy;
  logic              set_done;
  logic [NSLOT-1:0]  full_new;
  logic [HANDLE_W-1:0] in_handle;

  assign out_free  = !out_o.valid || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE) && out_free;
  assign in_fire   = in_i.valid && in_i.ready;
  assign ch_idx    = in_i.channel[AW-1:0];
  assign ch_bad    = (CFG_W'(in_i.channel) >= n_act);
  assign ch_busy   = full_q[ch_idx];
  assign in_handle = HANDLE_W'(in_i.buffer_handle[KB-1:0]);

  always_comb begin
    full_new         = full_q;
    full_new[ch_idx] = 1'b1;
    set_done         = ((full_new & act_mask) == act_mask);
  end

  // Emit-pass selection for the current slot.
  logic             all_eq;
  logic             emit_sel;
  logic [NSLOT-1:0] hi_mask;
  logic             emit_last;

  assign all_eq   = (mask_q == '0);
  assign emit_sel = all_eq || mask_q[idx_q];

  always_comb begin
    for (int j = 0; j < NSLOT; j++) begin
      hi_mask[j] = (AW'(j) > idx_q) && (j < NSLOT);
    end
    emit_last = all_eq ? (idx_q == last_idx) : ((mask_q & hi_mask) == '0);
  end

  // Next state and counters.
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    wait_d  = wait_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && !ch_bad && !ch_busy && set_done) begin
          state_d = ST_SCAN;
          idx_d   = '0;
          wait_d  = in_i.consumer_waiting;
        end
      end
      ST_SCAN: begin
        if (idx_q == last_idx) begin
          state_d = ST_SCAN_END;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end
      ST_SCAN_END: begin
        state_d = ST_EMIT_RD;
        idx_d   = '0;
      end
      ST_EMIT_RD: begin
        if (emit_sel) begin
          state_d = ST_EMIT_WAIT;
        end else if (idx_q == last_idx) begin
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end
      ST_EMIT_WAIT: begin
        if (out_free) begin
          if (emit_last) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_EMIT_RD;
            idx_d   = idx_q + AW'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Memory access strobes.
  always_comb begin
    mem_we    = in_fire && !ch_bad && !ch_busy;
    mem_waddr = ch_idx;
    mem_wdata = {in_i.frame_time, in_i.buffer_handle[KB-1:0]};
    mem_re    = (state_q == ST_SCAN) || ((state_q == ST_EMIT_RD) && emit_sel);
  end

  // Result to load into the output register this cycle.
  logic                load_out;
  kind_e               kind_n;
  logic [CHAN_W-1:0]   chan_n;
  logic [HANDLE_W-1:0] handle_n;
  logic [TIME_W-1:0]   time_n;
  logic                last_n;

  always_comb begin
    load_out = 1'b0;
    kind_n   = KIND_BADCHAN;
    chan_n   = in_i.channel;
    handle_n = in_handle;
    time_n   = in_i.frame_time;
    last_n   = 1'b1;
    if (state_q == ST_EMIT_WAIT) begin
      load_out = out_free;
      if (!all_eq) begin
        kind_n = KIND_RELEASED;
      end else if (wait_q) begin
        kind_n = KIND_DELIVERED;
      end else begin
        kind_n = KIND_SKIPPED;
      end
      chan_n   = CHAN_W'(idx_q);
      handle_n = HANDLE_W'(rd_handle);
      time_n   = rd_time;
      last_n   = emit_last;
    end else if (in_fire && (ch_bad || ch_busy)) begin
      load_out = 1'b1;
      kind_n   = ch_bad ? KIND_BADCHAN : KIND_BUSY;
    end
  end

  // Control registers and slot flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      wait_q      <= 1'b0;
      full_q      <= '0;
      scan_v_q    <= 1'b0;
      out_o.valid <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      wait_q   <= wait_d;
      scan_v_q <= (state_q == ST_SCAN);
      if (mem_we) begin
        full_q[ch_idx] <= 1'b1;
      end else if (load_out && (state_q == ST_EMIT_WAIT)) begin
        full_q[idx_q] <= 1'b0;
      end
      if (load_out) begin
        out_o.valid <= 1'b1;
      end else if (out_o.ready) begin
        out_o.valid <= 1'b0;
      end
    end
  end

  // Scan datapath: running maximum and the set of slots below it.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_SCAN) begin
      ridx_q <= idx_q;
    end
    if (scan_v_q) begin
      if ((ridx_q == '0) || (rd_time > max_q)) begin
        max_q <= rd_time;
        for (int j = 0; j < NSLOT; j++) begin
          mask_q[j] <= (AW'(j) < ridx_q);
        end
      end else if (rd_time < max_q) begin
        mask_q[ridx_q] <= 1'b1;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_o.kind        <= kind_n;
      out_o.out_channel <= chan_n;
      out_o.out_handle  <= handle_n;
      out_o.out_time    <= time_n;
      out_o.last        <= last_n;
    end
  end

endmodule

`default_nettype wire
